### rtl/core/bda_pkg.sv
// shared types, constants and helpers for the button debounce block
package bda_pkg;

   localparam int TICK_W     = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int EVENT_W    = 4;

   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [EVENT_W-1:0] event_type;

   localparam int EV_PRESSED  = 0;
   localparam int EV_RELEASED = 1;
   localparam int EV_HELD     = 2;
   localparam int EV_REPEATED = 3;

   typedef enum logic [3:0] {
      PH_RELEASED  = 4'b0001,
      PH_ENGAGED   = 4'b0010,
      PH_PRESSED   = 4'b0100,
      PH_REPEATING = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      ACT_IDLE     = 3'd0,
      ACT_PRESSED  = 3'd1,
      ACT_RELEASED = 3'd2,
      ACT_HELD     = 3'd3,
      ACT_REPEATED = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      REG_DEAD_TIME     = 2'd0,
      REG_REPEAT_DELAY  = 2'd1,
      REG_REPEAT_PERIOD = 2'd2,
      REG_UNMAPPED      = 2'd3
   } reg_index_type;

   typedef struct packed {
      tick_type dead_time;
      tick_type repeat_delay;
      tick_type repeat_period;
   } cfg_type;

   // wrapping compare: interval has passed since base when the difference is non-negative
   function automatic logic elapsed(input tick_type now, input tick_type base,
                                    input tick_type interval);
      tick_type diff;
      diff = now - base - interval;
      return ~diff[TICK_W-1];
   endfunction

endpackage

### rtl/core/bda_csr.sv
// configuration registers behind the apb-style port
module bda_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bda_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bda_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output bda_pkg::cfg_type               cfg
);

   bda_pkg::cfg_type      cfg_ff;
   bda_pkg::cfg_type      cfg_in;
   bda_pkg::reg_index_type index;
   logic                  write_en;
   bda_pkg::tick_type     wdata;
   bda_pkg::tick_type     rdata;

   assign index      = bda_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata      = csr_pwdata[bda_pkg::TICK_W-1:0];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            bda_pkg::REG_DEAD_TIME:     cfg_in.dead_time     = wdata;
            bda_pkg::REG_REPEAT_DELAY:  cfg_in.repeat_delay  = wdata;
            bda_pkg::REG_REPEAT_PERIOD: cfg_in.repeat_period = wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bda_pkg::REG_DEAD_TIME:     rdata = cfg_ff.dead_time;
         bda_pkg::REG_REPEAT_DELAY:  rdata = cfg_ff.repeat_delay;
         bda_pkg::REG_REPEAT_PERIOD: rdata = cfg_ff.repeat_period;
         default:                    rdata = '0;
      endcase
   end

   assign csr_prdata = {{(bda_pkg::CSR_DATA_W-bda_pkg::TICK_W){1'b0}}, rdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/bda_step.sv
// debounce state, repeat timing and pending event selection
module bda_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bda_pkg::tick_type      now_time,
   input  logic                   button_level,
   input  bda_pkg::cfg_type       cfg,
   output bda_pkg::action_type    action
);

   bda_pkg::phase_type phase_ff;
   bda_pkg::phase_type phase_in;
   bda_pkg::event_type pending_ff;
   bda_pkg::event_type pending_in;
   bda_pkg::tick_type  time_ff;
   bda_pkg::tick_type  time_in;

   always_comb begin
      bda_pkg::phase_type ph;
      bda_pkg::event_type ev;
      bda_pkg::tick_type  t;
      ph = phase_ff;
      ev = pending_ff;
      t  = time_ff;

      // dead time after release
      if (ph == bda_pkg::PH_RELEASED && bda_pkg::elapsed(now_time, t, cfg.dead_time)) begin
         ph = bda_pkg::PH_ENGAGED;
      end

      // press and release edges
      if (button_level) begin
         if (ph == bda_pkg::PH_ENGAGED) begin
            ph = bda_pkg::PH_PRESSED;
            ev = '0;
            ev[bda_pkg::EV_PRESSED] = 1'b1;
            t  = now_time;
         end
      end else if (ph == bda_pkg::PH_PRESSED || ph == bda_pkg::PH_REPEATING) begin
         ph = bda_pkg::PH_RELEASED;
         ev = '0;
         ev[bda_pkg::EV_RELEASED] = 1'b1;
         t  = now_time;
      end

      // auto-repeat timing
      if (ph == bda_pkg::PH_REPEATING) begin
         if (bda_pkg::elapsed(now_time, t, cfg.repeat_period)) begin
            ev[bda_pkg::EV_REPEATED] = 1'b1;
            t = t + cfg.repeat_period;
         end
      end else if (ph == bda_pkg::PH_PRESSED) begin
         if (bda_pkg::elapsed(now_time, t, cfg.repeat_delay)) begin
            ph = bda_pkg::PH_REPEATING;
            ev[bda_pkg::EV_HELD]     = 1'b1;
            ev[bda_pkg::EV_REPEATED] = 1'b1;
            t = t + cfg.repeat_delay;
         end
      end

      // report and clear the highest-priority pending event
      priority if (ev[bda_pkg::EV_PRESSED]) begin
         ev[bda_pkg::EV_PRESSED] = 1'b0;
         action = bda_pkg::ACT_PRESSED;
      end else if (ev[bda_pkg::EV_RELEASED]) begin
         ev[bda_pkg::EV_RELEASED] = 1'b0;
         action = bda_pkg::ACT_RELEASED;
      end else if (ev[bda_pkg::EV_HELD]) begin
         ev[bda_pkg::EV_HELD] = 1'b0;
         action = bda_pkg::ACT_HELD;
      end else if (ev[bda_pkg::EV_REPEATED]) begin
         ev[bda_pkg::EV_REPEATED] = 1'b0;
         action = bda_pkg::ACT_REPEATED;
      end else begin
         action = bda_pkg::ACT_IDLE;
      end

      phase_in   = ph;
      pending_in = ev;
      time_in    = t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bda_pkg::PH_ENGAGED;
         pending_ff <= '0;
         time_ff    <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         time_ff    <= time_in;
      end
   end

endmodule

### rtl/core/button_debounce_autorepeat.sv
// Button debounce with auto-repeat: each timestamped sample transaction on req_ yields exactly
// one action transaction on rsp_ (idle, pressed, released, held or repeated). A sample is
// captured in an input register; then, once the result register is free or being taken, the
// state update and event selection run in one pass into the result register. One sample per
// cycle is sustained while rsp_ready stays high; the rate is set by the state update loop.
// The result register lets a new sample enter while the previous result waits to be taken.
// Configuration registers (dead_time at 0x0, repeat_delay at 0x4, repeat_period at 0x8) reset
// to zero; the user must write them only while no transaction is in flight, which the block
// itself does not enforce. Reset is synchronous and needs no clearing pass.
module button_debounce_autorepeat (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_now_time,
   input  logic                           req_button_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_action,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bda_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bda_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   bda_pkg::cfg_type    cfg;
   bda_pkg::action_type action;

   logic                in_valid_ff;
   logic                in_valid_in;
   bda_pkg::tick_type   now_ff;
   logic                level_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   bda_pkg::action_type action_ff;
   logic                req_fire;
   logic                advance;

   bda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bda_step u_step (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .now_time     (now_ff),
      .button_level (level_ff),
      .cfg          (cfg),
      .action       (action)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff   <= req_now_time;
         level_ff <= req_button_level;
      end
      if (advance) begin
         action_ff <= action;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = action_ff;

endmodule
